// File: rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, constants and helpers of the metasprite expander.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  // build defaults
  localparam int NUM_SPRITES_DEF   = 128;
  localparam int SPRITE_ORIGIN_DEF = 16;
  localparam int MAX_SPAN_DEF      = 8;

  // fixed by the field widths
  localparam int CELL_PIX    = 16;
  localparam int POS_W       = 18;  // pixel position plus seven cell steps, signed
  localparam int SLOT_CNT_W  = 8;
  localparam int IDX_W       = 3;   // column/row index, spans of up to 8
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [9:0] SCREEN_W_RST = 10'd320;
  localparam logic [9:0] SCREEN_H_RST = 10'd224;

  // register index, taken from paddr[2]
  localparam logic REG_SCREEN_W = 1'b0;
  localparam logic REG_SCREEN_H = 1'b1;

  localparam logic CMD_START_FRAME = 1'b0;
  localparam logic CMD_DRAW        = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]       tile_base;
    logic [7:0]        frame_idx;
    logic [3:0]        cell_cols;
    logic [3:0]        cell_rows;
    logic [3:0]        palette_block;
    logic              mirror;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  slot;
    logic [9:0]  sprite_x;
    logic [9:0]  sprite_y;
    logic [15:0] attribute;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_slots;
    logic load;
    logic area;
    logic base;
    logic step;
    logic flush;
  } mse_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic in_draw;
    logic in_empty;
    logic at_end;
    logic advance;
    logic pend_valid;
    logic out_free;
  } mse_st_t;

  function automatic logic [3:0] clamp_span(input logic [3:0] v, input logic [3:0] lim);
    clamp_span = (v > lim) ? lim : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mse_regs.sv
// ----------------------------------------------------------------------------
// mse_regs
// APB-style register file holding the clipping screen size.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_regs
  import mse_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [9:0]            screen_width,
  output logic      [9:0]            screen_height
);

  logic [9:0] screen_w_r, screen_w_nxt;
  logic [9:0] screen_h_r, screen_h_nxt;
  logic       wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    screen_w_nxt = screen_w_r;
    screen_h_nxt = screen_h_r;
    if (wr_en) begin
      case (paddr[2])
        REG_SCREEN_W: screen_w_nxt = pwdata[9:0];
        REG_SCREEN_H: screen_h_nxt = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_W_RST;
      screen_h_r <= SCREEN_H_RST;
    end else begin
      screen_w_r <= screen_w_nxt;
      screen_h_r <= screen_h_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCREEN_W: prdata = {{(CFG_DATA_W-10){1'b0}}, screen_w_r};
      REG_SCREEN_H: prdata = {{(CFG_DATA_W-10){1'b0}}, screen_h_r};
      default:      prdata = '0;
    endcase
  end

  assign screen_width  = screen_w_r;
  assign screen_height = screen_h_r;

endmodule

`default_nettype wire

// File: rtl/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: takes a request, sets up the tile base, walks the cell grid and
// flushes the final entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ctrl
  import mse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire mse_st_t  st,
  output mse_ctl_t      ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AREA,
    S_BASE,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!st.in_draw) begin
            ctl.clear_slots = 1'b1;
          end else if (!st.in_empty) begin
            ctl.load  = 1'b1;
            state_nxt = S_AREA;
          end
        end
      end
      S_AREA: begin
        ctl.area  = 1'b1;
        state_nxt = S_BASE;
      end
      S_BASE: begin
        ctl.base  = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        ctl.step = 1'b1;
        if (st.advance && st.at_end) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          ctl.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

`default_nettype wire

// File: rtl/mse_dp.sv
// ----------------------------------------------------------------------------
// mse_dp
// Datapath: request registers, cell walk counters, clipping, slot counter,
// one-entry hold stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_dp
  import mse_pkg::*;
#(
  parameter int NUM_SPRITES   = NUM_SPRITES_DEF,
  parameter int SPRITE_ORIGIN = SPRITE_ORIGIN_DEF,
  parameter int MAX_SPAN      = MAX_SPAN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire mse_ctl_t  ctl,
  output mse_st_t        st,
  input  wire in_item_t  in_data,
  input  wire logic [9:0] screen_width,
  input  wire logic [9:0] screen_height,
  output logic           out_valid,
  output out_item_t      out_data,
  input  wire logic      out_stall
);

  localparam logic [3:0]            SPAN_LIM  = 4'(MAX_SPAN);
  localparam logic [SLOT_CNT_W-1:0] SLOT_LIM  = SLOT_CNT_W'(NUM_SPRITES);
  localparam logic [9:0]            ORIGIN    = 10'(SPRITE_ORIGIN);
  localparam logic signed [POS_W-1:0] STEP    = POS_W'(CELL_PIX);
  localparam logic signed [POS_W-1:0] CLIP_LO = -POS_W'(CELL_PIX - 1);

  // request
  logic signed [POS_W-1:0] y0_r;
  logic [7:0]              first_r;
  logic [7:0]              anim_r;
  logic [3:0]              cols_r, rows_r;
  logic [3:0]              pal_r;
  logic                    mirror_r;
  logic [6:0]              area_r;

  // walk
  logic signed [POS_W-1:0] cur_x_r, cur_y_r;
  logic [7:0]              col_tile_r, tile_r;
  logic [IDX_W-1:0]        c_r, r_r;
  logic [SLOT_CNT_W-1:0]   slot_cnt_r;

  // hold stage and output register
  out_item_t pend_r;
  logic      pend_valid_r;
  out_item_t out_r;
  logic      out_valid_r;

  logic [7:0]  base_w, ofs_w, rows8, col_tile_nxt;
  logic        vis_x, vis_y, keep, out_free, advance, r_last, c_last;
  out_item_t   cell_w;
  out_item_t   pend_last_w;

  assign rows8   = {4'd0, rows_r};
  assign base_w  = first_r + 8'(anim_r * {1'b0, area_r});
  assign ofs_w   = mirror_r ? 8'({1'b0, area_r} - rows8) : 8'd0;
  assign col_tile_nxt = mirror_r ? (col_tile_r - rows8) : (col_tile_r + rows8);

  assign vis_x = (cur_x_r >= CLIP_LO) && (cur_x_r < $signed({8'd0, screen_width}));
  assign vis_y = (cur_y_r >= CLIP_LO) && (cur_y_r < $signed({8'd0, screen_height}));
  assign keep  = vis_x && vis_y && (slot_cnt_r < SLOT_LIM);

  assign out_free = !out_valid_r || !out_stall;
  // a kept cell with the hold stage full needs room in the output register
  assign advance  = !(keep && pend_valid_r && !out_free);
  assign r_last   = (r_r == IDX_W'(rows_r - 4'd1));
  assign c_last   = (c_r == IDX_W'(cols_r - 4'd1));

  always_comb begin
    cell_w.slot      = slot_cnt_r[6:0];
    cell_w.sprite_x  = cur_x_r[9:0] + ORIGIN;
    cell_w.sprite_y  = cur_y_r[9:0] + ORIGIN;
    cell_w.attribute = {1'b0, mirror_r, 2'b00, pal_r, tile_r};
    cell_w.last      = 1'b0;
    // held entry marked as the final one of its actor
    pend_last_w      = pend_r;
    pend_last_w.last = 1'b1;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      y0_r     <= POS_W'(in_data.pos_y);
      cur_x_r  <= POS_W'(in_data.pos_x);
      cur_y_r  <= POS_W'(in_data.pos_y);
      first_r  <= in_data.tile_base[7:0];
      anim_r   <= in_data.frame_idx;
      cols_r   <= clamp_span(in_data.cell_cols, SPAN_LIM);
      rows_r   <= clamp_span(in_data.cell_rows, SPAN_LIM);
      pal_r    <= in_data.palette_block;
      mirror_r <= in_data.mirror;
      c_r      <= '0;
      r_r      <= '0;
    end
    if (ctl.area) begin
      area_r <= 7'({3'd0, cols_r} * {3'd0, rows_r});
    end
    if (ctl.base) begin
      tile_r     <= base_w + ofs_w;
      col_tile_r <= base_w + ofs_w;
    end
    if (ctl.step && advance) begin
      if (keep) begin
        pend_r <= cell_w;
      end
      if (r_last) begin
        r_r        <= '0;
        c_r        <= c_r + IDX_W'(1);
        cur_y_r    <= y0_r;
        cur_x_r    <= cur_x_r + STEP;
        col_tile_r <= col_tile_nxt;
        tile_r     <= col_tile_nxt;
      end else begin
        r_r     <= r_r + IDX_W'(1);
        cur_y_r <= cur_y_r + STEP;
        tile_r  <= tile_r + 8'd1;
      end
    end
    if (ctl.step && advance && keep && pend_valid_r) begin
      out_r <= pend_r;
    end else if (ctl.flush) begin
      out_r <= pend_last_w;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.clear_slots) begin
        slot_cnt_r <= '0;
      end else if (ctl.step && advance && keep) begin
        slot_cnt_r <= slot_cnt_r + SLOT_CNT_W'(1);
      end

      if (ctl.flush) begin
        pend_valid_r <= 1'b0;
      end else if (ctl.step && advance && keep) begin
        pend_valid_r <= 1'b1;
      end

      if ((ctl.step && advance && keep && pend_valid_r) || ctl.flush) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.in_draw    = (in_data.cmd == CMD_DRAW);
    st.in_empty   = (in_data.cell_cols == 4'd0) || (in_data.cell_rows == 4'd0);
    st.at_end     = r_last && c_last;
    st.advance    = advance;
    st.pend_valid = pend_valid_r;
    st.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/metasprite_expander.sv
// ----------------------------------------------------------------------------
// metasprite_expander
// Expands actor draw requests into hardware sprite entries.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): one item is either a start-frame
// command, which clears the slot counter without stalling the input, or an
// actor draw request. A draw request of cols x rows cells (each clamped to
// MAX_SPAN) passes through the area and base set-up steps, the grid walk and
// a flush step; the walk visits one cell per cycle, column by column, unless
// the output backs up and holds it. A request of zero size finishes at once.
// in_stall is high from acceptance of a draw until its last entry has gone
// into the output register.
// Output channel (out_valid/out_stall/out_data): one sprite entry per item.
// Each entry waits in the hold stage until the next kept cell, so that the
// final one can carry last; the flush sends out the final one. Clipped
// cells and cells beyond NUM_SPRITES give no entry. While the receiver
// stalls, the output register holds its entry and the walk pauses at the
// next visible cell.
// Reset puts the block idle with the slot counter at zero, screen width 320
// and height 224. Width (0x0) and height (0x4) are written over the APB-style
// port; the user must write only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module metasprite_expander
  import mse_pkg::*;
#(
  parameter int NUM_SPRITES   = NUM_SPRITES_DEF,
  parameter int SPRITE_ORIGIN = SPRITE_ORIGIN_DEF,
  parameter int MAX_SPAN      = MAX_SPAN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [9:0] screen_width, screen_height;
  mse_ctl_t   ctl;
  mse_st_t    st;

  mse_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  mse_dp #(
    .NUM_SPRITES   (NUM_SPRITES),
    .SPRITE_ORIGIN (SPRITE_ORIGIN),
    .MAX_SPAN      (MAX_SPAN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .st            (st),
    .in_data       (in_data),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_stall     (out_stall)
  );

endmodule

`default_nettype wire

// File: rtl/mse_checker.sv
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the metasprite expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_checker
  import mse_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data,
  input wire logic      pready
);

  // a stalled entry is held
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  // an entry that is not the last of its actor means the actor is still busy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("non-last item shown while input is open");

  // a non-empty draw request keeps the input closed while it expands
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == CMD_DRAW) &&
    (in_data.cell_cols != 4'd0) && (in_data.cell_rows != 4'd0) |=> in_stall)
    else $error("input not stalled after draw request");

  // a start-frame command does not stall the input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == CMD_START_FRAME) |=> !in_stall)
    else $error("start-frame command stalled the input");

  assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind metasprite_expander mse_checker u_mse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

`default_nettype wire

// File: test/tb_metasprite_expander.sv
// ----------------------------------------------------------------------------
// tb_metasprite_expander
// Self-checking bench for the metasprite expander: actor draw requests and
// frame starts go in, and every sprite entry that comes out is checked against
// an in-bench prediction of slot, position, attribute and last flag. The run
// covers directed corner cases, then random traffic under several screen
// sizes, with random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module tb_metasprite_expander;
  timeunit 1ns;
  timeprecision 1ps;

  import mse_pkg::*;

  localparam int IDLE_PCT      = 11;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  // predicts sprite entries and checks them in order
  class sprite_scoreboard;
    logic [9:0]  scr_w;
    logic [9:0]  scr_h;
    int unsigned slots_used;
    out_item_t   entry_q[$];
    int          errors;
    int          entries_seen;
    int          draws;
    int          frames;

    function new();
      scr_w = SCREEN_W_RST;
      scr_h = SCREEN_H_RST;
      slots_used = 0;
      errors = 0;
      entries_seen = 0;
      draws = 0;
      frames = 0;
    endfunction

    function void note_input(in_item_t it);
      int          px, py, sx, sy, w, h, c, r, emitted;
      int unsigned cols, rows, src, base, tile;
      out_item_t   e;
      if (it.cmd == CMD_START_FRAME) begin
        slots_used = 0;
        frames++;
        return;
      end
      draws++;
      px = $signed(it.pos_x);
      py = $signed(it.pos_y);
      w = scr_w;
      h = scr_h;
      cols = (it.cell_cols > MAX_SPAN_DEF) ? MAX_SPAN_DEF : it.cell_cols;
      rows = (it.cell_rows > MAX_SPAN_DEF) ? MAX_SPAN_DEF : it.cell_rows;
      base = (it.tile_base + it.frame_idx * cols * rows) & 32'hFFFF;
      emitted = 0;
      for (c = 0; c < cols; c++) begin
        src = it.mirror ? (cols - 1 - c) : c;
        for (r = 0; r < rows; r++) begin
          sx = px + c * CELL_PIX;
          sy = py + r * CELL_PIX;
          if (sx <= -CELL_PIX || sx >= w) continue;
          if (sy <= -CELL_PIX || sy >= h) continue;
          if (slots_used >= NUM_SPRITES_DEF) continue;
          tile = base + src * rows + r;
          e.slot      = 7'(slots_used);
          e.sprite_x  = 10'(sx + SPRITE_ORIGIN_DEF);
          e.sprite_y  = 10'(sy + SPRITE_ORIGIN_DEF);
          e.attribute = {1'b0, it.mirror, 2'b00, it.palette_block, tile[7:0]};
          e.last      = 1'b0;
          entry_q.push_back(e);
          slots_used++;
          emitted++;
        end
      end
      if (emitted > 0) entry_q[entry_q.size() - 1].last = 1'b1;
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      entries_seen++;
      if (entry_q.size() == 0) begin
        $error("unexpected sprite entry for slot %0d", got.slot);
        errors++;
        return;
      end
      want = entry_q.pop_front();
      check_field("slot", want.slot, got.slot);
      check_field("sprite_x", want.sprite_x, got.sprite_x);
      check_field("sprite_y", want.sprite_y, got.sprite_y);
      check_field("attribute", want.attribute, got.attribute);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic calm = 1'b0;
  logic hold_off = 1'b0;
  logic squeeze_go = 1'b0;

  sprite_scoreboard board = new();

  metasprite_expander DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= hold_off || (!calm && $urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // long receiver hold so the block backs up into its input
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL metasprite_expander");
    $finish;
  end

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic cfg_access(input logic idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    cfg_access(REG_SCREEN_W, 1'b0, '0, rd);
    if (rd[9:0] !== board.scr_w) begin
      $error("screen_width readback: expected %0d, got %0d", board.scr_w, rd[9:0]);
      board.errors++;
    end
    cfg_access(REG_SCREEN_H, 1'b0, '0, rd);
    if (rd[9:0] !== board.scr_h) begin
      $error("screen_height readback: expected %0d, got %0d", board.scr_h, rd[9:0]);
      board.errors++;
    end
  endtask

  task automatic set_screen(input int w, input int h);
    logic [31:0] rd;
    cfg_access(REG_SCREEN_W, 1'b1, 32'(w), rd);
    cfg_access(REG_SCREEN_H, 1'b1, 32'(h), rd);
    board.scr_w = 10'(w);
    board.scr_h = 10'(h);
    check_regs();
  endtask

  // the block may still walk clipped cells after the last entry is out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.entry_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t actor(int x, int y, int tile, int frame, int cols, int rows,
                                     int pal, bit flip);
    in_item_t it;
    it.cmd           = CMD_DRAW;
    it.pos_x         = 16'(x);
    it.pos_y         = 16'(y);
    it.tile_base     = 16'(tile);
    it.frame_idx     = 8'(frame);
    it.cell_cols     = 4'(cols);
    it.cell_rows     = 4'(rows);
    it.palette_block = 4'(pal);
    it.mirror        = flip;
    return it;
  endfunction

  function automatic in_item_t frame_start();
    in_item_t it;
    it     = in_item_t'({$urandom, $urandom, $urandom});
    it.cmd = CMD_START_FRAME;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       w, h, pick;
    w = board.scr_w;
    h = board.scr_h;
    it = in_item_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(0, 99) < 10) begin
      it.cmd = CMD_START_FRAME;
      return it;
    end
    it.cmd = CMD_DRAW;
    // mostly around the visible area, sometimes anywhere in the 16-bit range
    if ($urandom_range(0, 99) < 80) begin
      it.pos_x = 16'(int'($urandom_range(0, w + 160)) - 144);
      it.pos_y = 16'(int'($urandom_range(0, h + 160)) - 144);
    end
    pick = $urandom_range(0, 99);
    it.cell_cols = (pick < 85) ? 4'($urandom_range(1, 4)) :
                   (pick < 95) ? 4'($urandom_range(5, 8)) : 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    it.cell_rows = (pick < 85) ? 4'($urandom_range(1, 4)) :
                   (pick < 95) ? 4'($urandom_range(5, 8)) : 4'($urandom_range(0, 15));
    return it;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_regs();

    // directed part at reset screen size 320x224
    send_item(frame_start());
    send_item(actor(0, 0, 0, 0, 1, 1, 0, 1'b0));
    send_item(actor(-16, 0, 5, 0, 2, 1, 1, 1'b0));
    send_item(actor(-15, -15, 7, 1, 1, 1, 2, 1'b0));
    send_item(actor(-16, -16, 3, 0, 1, 1, 3, 1'b0));
    send_item(actor(319, 223, 9, 0, 1, 1, 4, 1'b1));
    send_item(actor(320, 0, 9, 0, 1, 1, 4, 1'b0));
    send_item(actor(0, 224, 9, 0, 1, 1, 4, 1'b0));
    send_item(actor(-32768, 32767, 16'hFFFF, 255, 8, 8, 15, 1'b1));
    send_item(actor(32767, -32768, 0, 0, 8, 8, 0, 1'b0));
    send_item(actor(100, 60, 16'hFFFF, 255, 3, 2, 15, 1'b1));
    send_item(actor(100, 60, 16'h1234, 3, 3, 2, 6, 1'b0));
    send_item(actor(40, 40, 1, 1, 0, 4, 2, 1'b0));
    send_item(actor(40, 40, 1, 1, 3, 0, 2, 1'b1));
    send_item(actor(300, 200, 16'h00F0, 17, 4, 3, 9, 1'b1));
    // slot exhaustion: two full 8x8 actors fill every slot, the third gets none
    send_item(frame_start());
    send_item(actor(0, 0, 16'h0100, 2, 8, 8, 5, 1'b0));
    send_item(actor(0, 0, 16'h0200, 1, 15, 9, 10, 1'b1));
    send_item(actor(0, 0, 16'h0300, 0, 8, 8, 12, 1'b0));
    send_item(actor(8, 8, 16'h0400, 0, 1, 1, 1, 1'b0));
    send_item(frame_start());
    send_item(actor(8, 8, 16'h0400, 4, 2, 2, 1, 1'b1));
    wait_idle();

    set_screen(1023, 1023);
    calm <= 1'b1;
    repeat (80) send_item(random_item());
    wait_idle();
    calm <= 1'b0;

    set_screen(1, 1);
    repeat (50) send_item(random_item());
    wait_idle();

    set_screen($urandom_range(16, 700), $urandom_range(16, 500));
    squeeze_go <= 1'b1;
    repeat (120) send_item(random_item());
    wait_idle();

    if (board.entry_q.size() != 0) begin
      $error("%0d sprite entries never arrived", board.entry_q.size());
      board.errors++;
    end
    $display("covered %0d draw requests and %0d frame starts, %0d sprite entries checked",
             board.draws, board.frames, board.entries_seen);
    $display("screen sizes: reset, 1023x1023, 1x1 and random, with a %0d-cycle output hold",
             HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("PASS metasprite_expander");
    end else begin
      $display("FAIL metasprite_expander");
    end
    $finish;
  end

endmodule
